[rtl/contrast_about_frame_mean_assert.svh]
// assertion macros shared by the contrast block
`ifndef CONTRAST_ABOUT_FRAME_MEAN_ASSERT_SVH
`define CONTRAST_ABOUT_FRAME_MEAN_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CAFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CAFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cafm_pkg.sv]
// types and constants of the frame-mean contrast block
package cafm_pkg;

  // frame geometry
  localparam int FRAME_PIXELS = 65536;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);
  localparam int POS_W        = ADDR_W + 1;

  // pixel and arithmetic widths
  localparam int PIX_W   = 8;
  localparam int MEAN_W  = PIX_W;
  localparam int GAIN_W  = 10;
  localparam int FRAC_W  = 8;
  localparam int SUM_W   = ADDR_W + PIX_W;
  localparam int DIV_W   = POS_W + MEAN_W - 1;
  localparam int STEP_W  = $clog2(MEAN_W);
  localparam int PROD_W  = PIX_W + 1 + GAIN_W + 1;
  localparam int V_W     = PROD_W + 1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
  localparam logic [PIX_W-1:0]  PIX_MAX    = '1;

  // request kinds
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_READ = 1'b1
  } req_kind_t;

  // input transaction
  typedef struct packed {
    req_kind_t           req_type;
    logic [PIX_W-1:0]    pixel_in;
    logic                last_pixel;
    logic [15:0]         read_index;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [PIX_W-1:0]  pixel_out;
    logic [MEAN_W-1:0] frame_mean;
  } rsp_t;

  // frame store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } mem_wr_t;

  // mean divider request and status
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [POS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/contrast_about_frame_mean.sv]
// load item: accepted back to back; the frame store write port takes one pixel a cycle
// frame close: input held off while the divider makes 8 mean bits
// read item in frame: store read, product, then output register; next item once posted
// reset: clears position, sum, mean, frame flag and gain (256); store contents undefined
// a result waiting in the output register does not block loads
module contrast_about_frame_mean (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  cafm_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output cafm_pkg::rsp_t              rsp,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cafm_pkg::GAIN_W-1:0] cfg_data
);

`include "contrast_about_frame_mean_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RD   = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  state_t                          state, state_next;
  logic [cafm_pkg::POS_W-1:0]      pos;
  logic [cafm_pkg::SUM_W-1:0]      sum;
  logic [cafm_pkg::MEAN_W-1:0]     mean;
  logic                            frame_valid;
  logic [cafm_pkg::POS_W-1:0]      frame_length;
  logic [cafm_pkg::GAIN_W-1:0]     gain;

  logic                            req_acc;
  logic                            is_load;
  logic                            pos_in_range;
  logic [cafm_pkg::POS_W-1:0]      count_new;
  logic [cafm_pkg::SUM_W-1:0]      sum_new;
  logic                            rd_hit;
  logic                            out_free;
  cafm_pkg::mem_wr_t               mem_wr;
  logic                            rd_en;
  logic [cafm_pkg::PIX_W-1:0]      rd_data;
  cafm_pkg::div_req_t              div_req;
  cafm_pkg::div_rsp_t              div_rsp;
  logic [cafm_pkg::PIX_W-1:0]      adj_pixel;

  // handshakes
  assign req_ready = state == ST_IDLE;
  assign cfg_ready = 1'b1;
  assign req_acc   = req_valid && req_ready;
  assign is_load   = req.req_type == cafm_pkg::REQ_LOAD;
  assign out_free  = !rsp_valid || rsp_ready;

  // load bookkeeping
  assign pos_in_range = pos < cafm_pkg::POS_W'(cafm_pkg::FRAME_PIXELS);
  assign count_new    = pos_in_range ? pos + 1'b1 : pos;
  assign sum_new      = pos_in_range ? sum + cafm_pkg::SUM_W'(req.pixel_in) : sum;

  // read bounds
  assign rd_hit = frame_valid && (cafm_pkg::POS_W'(req.read_index) < frame_length);
  assign rd_en  = req_acc && !is_load && rd_hit;

  // store write for each in-range load
  assign mem_wr.en   = req_acc && is_load && pos_in_range;
  assign mem_wr.addr = pos[cafm_pkg::ADDR_W-1:0];
  assign mem_wr.data = req.pixel_in;

  // mean division at frame close
  assign div_req.start    = req_acc && is_load && req.last_pixel;
  assign div_req.dividend = sum_new;
  assign div_req.divisor  = count_new;

  cafm_frame_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_en   (rd_en),
    .rd_addr (req.read_index[cafm_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  cafm_mean_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cafm_adjust u_adj (
    .clk    (clk),
    .en     (state == ST_RD),
    .pix    (rd_data),
    .mean   (mean),
    .gain   (gain),
    .result (adj_pixel)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc) begin
          priority if (div_req.start) begin
            state_next = ST_DIV;
          end else if (rd_en) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      sum          <= '0;
      frame_valid  <= 1'b0;
      frame_length <= '0;
    end else if (req_acc && is_load) begin
      if (req.last_pixel) begin
        pos          <= '0;
        sum          <= '0;
        frame_valid  <= 1'b1;
        frame_length <= count_new;
      end else begin
        pos <= count_new;
        sum <= sum_new;
        if (pos == '0) begin
          frame_valid <= 1'b0;
        end
      end
    end
  end

  // mean latch
  always_ff @(posedge clk) begin
    if (rst) begin
      mean <= '0;
    end else if (div_rsp.done) begin
      mean <= div_rsp.quotient;
    end
  end

  // gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= cafm_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_MUL && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL && out_free) begin
      rsp.pixel_out  <= adj_pixel;
      rsp.frame_mean <= mean;
    end
  end

  // checks
  `CAFM_ASSERT_NOW(a_div_blocks_input, clk, rst, state == ST_DIV, !req_ready, "input taken during division")
  `CAFM_ASSERT_NOW(a_div_done_in_div, clk, rst, div_rsp.done, state == ST_DIV, "divider done outside division")
  `CAFM_ASSERT_NEXT(a_read_issues, clk, rst, rd_en, state == ST_RD, "read transaction not issued")
  `CAFM_ASSERT_NOW(a_frame_nonempty, clk, rst, frame_valid, frame_length != '0, "closed frame empty")
  `CAFM_ASSERT_NEXT(a_result_posted, clk, rst, state == ST_MUL && out_free, rsp_valid, "result lost")

endmodule

[rtl/cafm_frame_mem.sv]
// frame store: one write port, one registered read port
module cafm_frame_mem (
  input  logic                              clk,
  input  cafm_pkg::mem_wr_t                 wr,
  input  logic                              rd_en,
  input  logic [cafm_pkg::ADDR_W-1:0]       rd_addr,
  output logic [cafm_pkg::PIX_W-1:0]        rd_data
);

  logic [cafm_pkg::PIX_W-1:0] mem [2**cafm_pkg::ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/cafm_mean_div.sv]
// restoring divider for the frame mean, one quotient bit per cycle
module cafm_mean_div (
  input  logic                clk,
  input  logic                rst,
  input  cafm_pkg::div_req_t  req,
  output cafm_pkg::div_rsp_t  rsp
);

  logic                              busy;
  logic                              done;
  logic                              zero;
  logic [cafm_pkg::STEP_W-1:0]       cnt;
  logic [cafm_pkg::DIV_W-1:0]        rem;
  logic [cafm_pkg::DIV_W-1:0]        dsh;
  logic [cafm_pkg::MEAN_W-1:0]       q;
  logic                              ge;

  assign ge = rem >= dsh;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == cafm_pkg::STEP_W'(cafm_pkg::MEAN_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: subtract shifted divisor, high quotient bit first
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= cafm_pkg::DIV_W'(req.dividend);
      dsh  <= {req.divisor, {(cafm_pkg::MEAN_W - 1){1'b0}}};
      zero <= req.divisor == '0;
      q    <= '0;
      cnt  <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      q   <= {q[cafm_pkg::MEAN_W-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = zero ? '0 : q;

endmodule

[rtl/cafm_adjust.sv]
// contrast arithmetic: registered product, then offset and clamp
module cafm_adjust (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cafm_pkg::PIX_W-1:0]    pix,
  input  logic [cafm_pkg::MEAN_W-1:0]   mean,
  input  logic [cafm_pkg::GAIN_W-1:0]   gain,
  output logic [cafm_pkg::PIX_W-1:0]    result
);

  logic signed [cafm_pkg::PIX_W:0]    diff;
  logic signed [cafm_pkg::GAIN_W:0]   gain_s;
  logic signed [cafm_pkg::PROD_W-1:0] prod;
  logic signed [cafm_pkg::V_W-1:0]    base;
  logic signed [cafm_pkg::V_W-1:0]    v;

  // pixel minus mean times gain
  assign diff   = $signed({1'b0, pix}) - $signed({1'b0, mean});
  assign gain_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= diff * gain_s;
    end
  end

  // add mean in q.8 and clamp to pixel range
  assign base = $signed({{(cafm_pkg::V_W - cafm_pkg::MEAN_W - cafm_pkg::FRAC_W){1'b0}},
                         mean, {cafm_pkg::FRAC_W{1'b0}}});
  assign v    = base + $signed({prod[cafm_pkg::PROD_W-1], prod});

  always_comb begin
    priority if (v[cafm_pkg::V_W-1]) begin
      result = '0;
    end else if (|v[cafm_pkg::V_W-2:cafm_pkg::FRAC_W+cafm_pkg::PIX_W]) begin
      result = cafm_pkg::PIX_MAX;
    end else begin
      result = v[cafm_pkg::FRAC_W+cafm_pkg::PIX_W-1:cafm_pkg::FRAC_W];
    end
  end

endmodule
